### sv/lsrsg_pkg.sv
`default_nettype none

package lsrsg_pkg;

    typedef enum logic [1:0] {
        LD_WAIT    = 2'd0,
        LD_DELAY   = 2'd1,
        LD_DEPOSIT = 2'd2,
        LD_RESET   = 2'd3
    } loader_phase_t;

    typedef enum logic [1:0] {
        RL_IN   = 2'd0,
        RL_OUT  = 2'd1,
        RL_STOP = 2'd2
    } roller_phase_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_INWARD_SPEED     = 3'd0;
    localparam logic [2:0] CFG_OUTWARD_SPEED    = 3'd1;
    localparam logic [2:0] CFG_IDLE_ANGLE       = 3'd2;
    localparam logic [2:0] CFG_DEPOSIT_ANGLE    = 3'd3;
    localparam logic [2:0] CFG_STOP_STALL_MS    = 3'd4;
    localparam logic [2:0] CFG_REVERSE_STALL_MS = 3'd5;
    localparam logic [2:0] CFG_DETECT_DELAY_MS  = 3'd6;
    localparam logic [2:0] CFG_SERVO_MOVE_MS    = 3'd7;

    localparam logic [7:0]  RST_INWARD_SPEED     = 8'd255;
    localparam logic [7:0]  RST_OUTWARD_SPEED    = 8'd200;
    localparam logic [7:0]  RST_IDLE_ANGLE       = 8'd0;
    localparam logic [7:0]  RST_DEPOSIT_ANGLE    = 8'd150;
    localparam logic [31:0] RST_STOP_STALL_MS    = 32'd5000;
    localparam logic [31:0] RST_REVERSE_STALL_MS = 32'd500;
    localparam logic [31:0] RST_DETECT_DELAY_MS  = 32'd1000;
    localparam logic [31:0] RST_SERVO_MOVE_MS    = 32'd500;

    typedef struct packed {
        logic [7:0]  inward_speed;
        logic [7:0]  outward_speed;
        logic [7:0]  idle_angle;
        logic [7:0]  deposit_angle;
        logic [31:0] stop_stall_ms;
        logic [31:0] reverse_stall_ms;
        logic [31:0] detect_delay_ms;
        logic [31:0] servo_move_ms;
    } cfg_t;

    typedef struct packed {
        loader_phase_t loader_phase;
        roller_phase_t roller_phase;
        logic [31:0]   detect_stamp;
        logic [31:0]   deposit_stamp;
        logic [31:0]   return_stamp;
    } seq_state_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [31:0] last_pulse_ms;
        logic        item_seen;
    } tick_t;

    typedef struct packed {
        logic [7:0]    servo_angle;
        logic [7:0]    motor_speed;
        logic          motor_reverse;
        loader_phase_t loader_mode;
        roller_phase_t roller_mode;
    } result_t;

endpackage

`default_nettype wire

### sv/lsrsg_step.sv
`default_nettype none

module lsrsg_step
    import lsrsg_pkg::*;
(
    input  wire cfg_t       cfg,
    input  wire seq_state_t cur,
    input  wire tick_t      tick,
    output seq_state_t      nxt,
    output result_t         res
);

    logic [31:0] since_detect;
    logic [31:0] since_deposit;
    logic [31:0] since_return;
    logic [31:0] stall_time;

    // All elapsed times wrap modulo 2^32.
    assign since_detect  = tick.now_ms - cur.detect_stamp;
    assign since_deposit = tick.now_ms - cur.deposit_stamp;
    assign since_return  = tick.now_ms - cur.return_stamp;
    assign stall_time    = tick.now_ms - tick.last_pulse_ms;

    always_comb
    begin
        nxt = cur;

        unique case (cur.loader_phase)
            LD_WAIT:
            begin
                if (tick.item_seen)
                begin
                    nxt.loader_phase = LD_DELAY;
                    nxt.detect_stamp = tick.now_ms;
                end
            end
            LD_DELAY:
            begin
                if (since_detect > cfg.detect_delay_ms)
                begin
                    nxt.loader_phase  = LD_DEPOSIT;
                    nxt.deposit_stamp = tick.now_ms;
                end
            end
            LD_DEPOSIT:
            begin
                if (since_deposit > cfg.servo_move_ms)
                begin
                    nxt.loader_phase = LD_RESET;
                    nxt.return_stamp = tick.now_ms;
                end
            end
            LD_RESET:
            begin
                if (since_return > cfg.servo_move_ms)
                begin
                    nxt.loader_phase = LD_WAIT;
                end
            end
            default:
            begin
                nxt.loader_phase = LD_WAIT;
            end
        endcase

        // The stop threshold wins over the reverse threshold, and a stop is final.
        if (cur.roller_phase != RL_STOP)
        begin
            if (stall_time > cfg.stop_stall_ms)
            begin
                nxt.roller_phase = RL_STOP;
            end
            else if (stall_time > cfg.reverse_stall_ms)
            begin
                nxt.roller_phase = RL_OUT;
            end
            else
            begin
                nxt.roller_phase = RL_IN;
            end
        end

        res.servo_angle = (nxt.loader_phase == LD_DEPOSIT) ? cfg.deposit_angle
                                                           : cfg.idle_angle;
        res.loader_mode = nxt.loader_phase;
        res.roller_mode = nxt.roller_phase;

        unique case (nxt.roller_phase)
            RL_IN:
            begin
                res.motor_speed   = cfg.inward_speed;
                res.motor_reverse = 1'b0;
            end
            RL_OUT:
            begin
                res.motor_speed   = cfg.outward_speed;
                res.motor_reverse = 1'b1;
            end
            default:
            begin
                res.motor_speed   = 8'd0;
                res.motor_reverse = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/loader_sequencer_with_roller_stall_guard.sv
// Loader sequencer with roller stall guard.
//
// Input channel (in_valid / in_stall) carries one tick: now_ms, last_pulse_ms
// and item_seen. Output channel (out_valid / out_stall) returns one result per
// tick: servo_angle, motor_speed, motor_reverse, loader_mode and roller_mode.
// A transfer happens on a rising edge with valid high and stall low.
//
// A tick lands in an input register, passes through one layer of compare and
// subtract logic that also updates the sequencer state, and lands in the
// result register; a receiver stall can hold it back. Throughput is one tick
// per cycle without a stall, set by the single state update stage.
//
// When the receiver stalls, the result register holds its value and the input
// register stays full; in_stall rises only while both are full.
// Reset clears both valid flags and returns the configuration registers and
// the loader and roller state to their defaults. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at the next edge and should be
// issued only while no tick is in flight.
`default_nettype none

module loader_sequencer_with_roller_stall_guard
    import lsrsg_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data,

    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [31:0] now_ms,
    input  wire  [31:0] last_pulse_ms,
    input  wire         item_seen,

    output logic        out_valid,
    input  wire         out_stall,
    output logic [7:0]  servo_angle,
    output logic [7:0]  motor_speed,
    output logic        motor_reverse,
    output logic [1:0]  loader_mode,
    output logic [1:0]  roller_mode
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    tick_t      tick_reg;
    logic       tick_vld_reg;
    result_t    res_reg;
    result_t    res_next;
    logic       out_vld_reg;
    logic       advance;
    logic       in_take;

    assign advance  = tick_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = tick_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inward_speed     <= RST_INWARD_SPEED;
            cfg_reg.outward_speed    <= RST_OUTWARD_SPEED;
            cfg_reg.idle_angle       <= RST_IDLE_ANGLE;
            cfg_reg.deposit_angle    <= RST_DEPOSIT_ANGLE;
            cfg_reg.stop_stall_ms    <= RST_STOP_STALL_MS;
            cfg_reg.reverse_stall_ms <= RST_REVERSE_STALL_MS;
            cfg_reg.detect_delay_ms  <= RST_DETECT_DELAY_MS;
            cfg_reg.servo_move_ms    <= RST_SERVO_MOVE_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INWARD_SPEED:     cfg_reg.inward_speed     <= cfg_data[7:0];
                CFG_OUTWARD_SPEED:    cfg_reg.outward_speed    <= cfg_data[7:0];
                CFG_IDLE_ANGLE:       cfg_reg.idle_angle       <= cfg_data[7:0];
                CFG_DEPOSIT_ANGLE:    cfg_reg.deposit_angle    <= cfg_data[7:0];
                CFG_STOP_STALL_MS:    cfg_reg.stop_stall_ms    <= cfg_data;
                CFG_REVERSE_STALL_MS: cfg_reg.reverse_stall_ms <= cfg_data;
                CFG_DETECT_DELAY_MS:  cfg_reg.detect_delay_ms  <= cfg_data;
                CFG_SERVO_MOVE_MS:    cfg_reg.servo_move_ms    <= cfg_data;
                default:              cfg_reg.servo_move_ms    <= cfg_reg.servo_move_ms;
            endcase
        end
    end

    lsrsg_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .tick (tick_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            state_reg.loader_phase  <= LD_WAIT;
            state_reg.roller_phase  <= RL_IN;
            state_reg.detect_stamp  <= 32'd0;
            state_reg.deposit_stamp <= 32'd0;
            state_reg.return_stamp  <= 32'd0;
        end
        else
        begin
            if (in_take)
            begin
                tick_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                tick_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tick_reg.now_ms        <= now_ms;
            tick_reg.last_pulse_ms <= last_pulse_ms;
            tick_reg.item_seen     <= item_seen;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign servo_angle   = res_reg.servo_angle;
    assign motor_speed   = res_reg.motor_speed;
    assign motor_reverse = res_reg.motor_reverse;
    assign loader_mode   = res_reg.loader_mode;
    assign roller_mode   = res_reg.roller_mode;

    // Once stopped, the roller never restarts until reset.
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.roller_phase == RL_STOP |=> state_reg.roller_phase == RL_STOP)
        else $error("roller left the stopped state");

    // The loader only steps forward through its sequence, one state at a time.
    a_loader_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.loader_phase != $past(state_reg.loader_phase) |->
            state_reg.loader_phase == 2'($past(state_reg.loader_phase) + 2'd1))
        else $error("loader skipped or reversed a state");

    // A stopped roller is never driven.
    a_stop_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.roller_mode == RL_STOP |->
            res_reg.motor_speed == 8'd0 && !res_reg.motor_reverse)
        else $error("stopped roller has drive");

    // State advances only with a transfer into the result register.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a tick");

endmodule

`default_nettype wire

### bench/loader_sequencer_with_roller_stall_guard_tb.sv
`default_nettype none

module loader_sequencer_with_roller_stall_guard_tb;
    import lsrsg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int PRINT_LIMIT    = 50;

    typedef struct packed {
        tick_t   tick;
        logic    typed;
        result_t want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] now_ms;
    logic [31:0] last_pulse_ms;
    logic        item_seen;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  servo_angle;
    logic [7:0]  motor_speed;
    logic        motor_reverse;
    logic [1:0]  loader_mode;
    logic [1:0]  roller_mode;

    // Shadow copy of the sequencer, kept in step with every accepted tick.
    cfg_t          shadow_cfg = '{RST_INWARD_SPEED, RST_OUTWARD_SPEED, RST_IDLE_ANGLE,
                                  RST_DEPOSIT_ANGLE, RST_STOP_STALL_MS, RST_REVERSE_STALL_MS,
                                  RST_DETECT_DELAY_MS, RST_SERVO_MOVE_MS};
    loader_phase_t ld_phase      = LD_WAIT;
    roller_phase_t rl_phase      = RL_IN;
    logic [31:0]   detect_stamp  = '0;
    logic [31:0]   deposit_stamp = '0;
    logic [31:0]   return_stamp  = '0;

    result_t expected_q [$];

    // Side information for the tick currently offered on the input.
    logic    row_typed;
    result_t row_want;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_requests;
    int          hold_served;
    int          hold_left;
    int          quiet_cycles;
    int          ticks_in;
    int          results_checked;
    int          settings_loaded;
    int          backpressure_cycles;
    int          mismatches;
    logic [31:0] clock_ms;

    directed_row_t directed_rows [15] = '{
        // Reset defaults, plain waiting with no stall.
        '{'{32'd0, 32'd0, 1'b0}, 1'b1, '{8'd0, 8'd255, 1'b0, LD_WAIT, RL_IN}},
        '{'{32'd100, 32'd0, 1'b1}, 1'b1, '{8'd0, 8'd255, 1'b0, LD_DELAY, RL_IN}},
        // Elapsed equal to the delay does not yet end it.
        '{'{32'd1100, 32'd1100, 1'b0}, 1'b1, '{8'd0, 8'd255, 1'b0, LD_DELAY, RL_IN}},
        // One past the delay; an edge outside the waiting state is ignored.
        '{'{32'd1101, 32'd601, 1'b1}, 1'b1, '{8'd150, 8'd255, 1'b0, LD_DEPOSIT, RL_IN}},
        '{'{32'd1602, 32'd1101, 1'b0}, 1'b1, '{8'd0, 8'd200, 1'b1, LD_RESET, RL_OUT}},
        '{'{32'd2102, 32'd2102, 1'b0}, 1'b1, '{8'd0, 8'd255, 1'b0, LD_RESET, RL_IN}},
        '{'{32'd2103, 32'd0, 1'b0}, 1'b1, '{8'd0, 8'd200, 1'b1, LD_WAIT, RL_OUT}},
        // Detection just before the millisecond counter wraps.
        '{'{32'hFFFF_FF00, 32'hFFFF_FF00, 1'b1}, 1'b1,
          '{8'd0, 8'd255, 1'b0, LD_DELAY, RL_IN}},
        // Stall exactly at the stop threshold only reverses.
        '{'{32'd744, 32'hFFFF_EF60, 1'b0}, 1'b1, '{8'd0, 8'd200, 1'b1, LD_DELAY, RL_OUT}},
        '{'{32'd745, 32'd745, 1'b0}, 1'b1, '{8'd150, 8'd255, 1'b0, LD_DEPOSIT, RL_IN}},
        '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}, 1'b0, '{8'd0, 8'd0, 1'b0, LD_WAIT, RL_IN}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b0, '{8'd0, 8'd0, 1'b0, LD_WAIT, RL_IN}},
        '{'{32'hAAAA_AAAA, 32'hAAAA_A000, 1'b1}, 1'b0, '{8'd0, 8'd0, 1'b0, LD_WAIT, RL_IN}},
        '{'{32'h5555_5555, 32'h5555_5555, 1'b0}, 1'b0, '{8'd0, 8'd0, 1'b0, LD_WAIT, RL_IN}},
        '{'{32'd0, 32'hFFFF_FFFF, 1'b0}, 1'b0, '{8'd0, 8'd0, 1'b0, LD_WAIT, RL_IN}}
    };

    loader_sequencer_with_roller_stall_guard dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .now_ms        (now_ms),
        .last_pulse_ms (last_pulse_ms),
        .item_seen     (item_seen),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .servo_angle   (servo_angle),
        .motor_speed   (motor_speed),
        .motor_reverse (motor_reverse),
        .loader_mode   (loader_mode),
        .roller_mode   (roller_mode)
    );

    always #5 clk = ~clk;

    function automatic void load_register(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_INWARD_SPEED:     shadow_cfg.inward_speed     = data[7:0];
            CFG_OUTWARD_SPEED:    shadow_cfg.outward_speed    = data[7:0];
            CFG_IDLE_ANGLE:       shadow_cfg.idle_angle       = data[7:0];
            CFG_DEPOSIT_ANGLE:    shadow_cfg.deposit_angle    = data[7:0];
            CFG_STOP_STALL_MS:    shadow_cfg.stop_stall_ms    = data;
            CFG_REVERSE_STALL_MS: shadow_cfg.reverse_stall_ms = data;
            CFG_DETECT_DELAY_MS:  shadow_cfg.detect_delay_ms  = data;
            CFG_SERVO_MOVE_MS:    shadow_cfg.servo_move_ms    = data;
            default: ;
        endcase
    endfunction

    function automatic result_t advance_sequencer(input tick_t t);
        result_t     r;
        logic [31:0] elapsed;
        logic [31:0] stall;
        case (ld_phase)
            LD_WAIT:
                if (t.item_seen)
                begin
                    ld_phase     = LD_DELAY;
                    detect_stamp = t.now_ms;
                end
            LD_DELAY:
            begin
                elapsed = t.now_ms - detect_stamp;
                if (elapsed > shadow_cfg.detect_delay_ms)
                begin
                    ld_phase      = LD_DEPOSIT;
                    deposit_stamp = t.now_ms;
                end
            end
            LD_DEPOSIT:
            begin
                elapsed = t.now_ms - deposit_stamp;
                if (elapsed > shadow_cfg.servo_move_ms)
                begin
                    ld_phase     = LD_RESET;
                    return_stamp = t.now_ms;
                end
            end
            default:
            begin
                elapsed = t.now_ms - return_stamp;
                if (elapsed > shadow_cfg.servo_move_ms)
                    ld_phase = LD_WAIT;
            end
        endcase

        // The stop threshold wins over the reverse threshold, and a stop is final.
        if (rl_phase != RL_STOP)
        begin
            stall = t.now_ms - t.last_pulse_ms;
            if (stall > shadow_cfg.stop_stall_ms)
                rl_phase = RL_STOP;
            else if (stall > shadow_cfg.reverse_stall_ms)
                rl_phase = RL_OUT;
            else
                rl_phase = RL_IN;
        end

        r.servo_angle = (ld_phase == LD_DEPOSIT) ? shadow_cfg.deposit_angle
                                                 : shadow_cfg.idle_angle;
        case (rl_phase)
            RL_IN:
            begin
                r.motor_speed   = shadow_cfg.inward_speed;
                r.motor_reverse = 1'b0;
            end
            RL_OUT:
            begin
                r.motor_speed   = shadow_cfg.outward_speed;
                r.motor_reverse = 1'b1;
            end
            default:
            begin
                r.motor_speed   = 8'd0;
                r.motor_reverse = 1'b0;
            end
        endcase
        r.loader_mode = ld_phase;
        r.roller_mode = rl_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Result checking, tick prediction and the activity count for the watchdog.
    always @(posedge clk)
    begin : monitor
        result_t want;
        tick_t   tk;
        logic    moved;
        moved = 1'b0;
        if (out_valid && !out_stall)
        begin
            moved = 1'b1;
            if (expected_q.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_checked));
            else
            begin
                want = expected_q.pop_front();
                if (servo_angle !== want.servo_angle)
                    report_mismatch($sformatf("result %0d servo_angle got %0d expected %0d",
                                              results_checked, servo_angle, want.servo_angle));
                if (motor_speed !== want.motor_speed)
                    report_mismatch($sformatf("result %0d motor_speed got %0d expected %0d",
                                              results_checked, motor_speed, want.motor_speed));
                if (motor_reverse !== want.motor_reverse)
                    report_mismatch($sformatf("result %0d motor_reverse got %0d expected %0d",
                                              results_checked, motor_reverse,
                                              want.motor_reverse));
                if (loader_mode !== want.loader_mode)
                    report_mismatch($sformatf("result %0d loader_mode got %0d expected %0d",
                                              results_checked, loader_mode, want.loader_mode));
                if (roller_mode !== want.roller_mode)
                    report_mismatch($sformatf("result %0d roller_mode got %0d expected %0d",
                                              results_checked, roller_mode, want.roller_mode));
            end
            results_checked++;
        end
        if (in_valid && in_stall)
            backpressure_cycles++;
        if (in_valid && !in_stall)
        begin
            moved = 1'b1;
            tk.now_ms        = now_ms;
            tk.last_pulse_ms = last_pulse_ms;
            tk.item_seen     = item_seen;
            want = advance_sequencer(tk);
            expected_q.push_back(row_typed ? row_want : want);
            ticks_in++;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Watchdog: no transfer for %0d cycles, %0d results still expected",
                 WATCHDOG_LIMIT, expected_q.size());
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        out_stall   = 1'b0;
        hold_served = 0;
        hold_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Called just after a falling edge; returns just after the falling edge that
    // follows the transfer, with valid still high for the caller to reuse or drop.
    task automatic send_tick(input tick_t t, input logic typed, input result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        now_ms        <= t.now_ms;
        last_pulse_ms <= t.last_pulse_ms;
        item_seen     <= t.item_seen;
        row_typed     = typed;
        row_want      = want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(input cfg_t c, input int sender_pct, input int receiver_pct,
                             input int count, input int span, input int stall_span,
                             input int wild_pct, input logic hold_receiver);
        tick_t       t;
        logic [31:0] regs [8];
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);

        // Junk above the 8-bit registers must be dropped by the block.
        regs[CFG_INWARD_SPEED]     = {24'($urandom()), c.inward_speed};
        regs[CFG_OUTWARD_SPEED]    = {24'($urandom()), c.outward_speed};
        regs[CFG_IDLE_ANGLE]       = {24'($urandom()), c.idle_angle};
        regs[CFG_DEPOSIT_ANGLE]    = {24'($urandom()), c.deposit_angle};
        regs[CFG_STOP_STALL_MS]    = c.stop_stall_ms;
        regs[CFG_REVERSE_STALL_MS] = c.reverse_stall_ms;
        regs[CFG_DETECT_DELAY_MS]  = c.detect_delay_ms;
        regs[CFG_SERVO_MOVE_MS]    = c.servo_move_ms;
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= regs[i];
            load_register(3'(i), regs[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        settings_loaded++;

        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        if (hold_receiver)
            hold_requests++;
        for (int n = 0; n < count; n++)
        begin
            // Mostly a steadily advancing clock with recent pulses, now and then a jump.
            if ($urandom_range(99) < wild_pct)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(0, span);
            t.now_ms = clock_ms;
            if ($urandom_range(99) < wild_pct)
                t.last_pulse_ms = $urandom();
            else
                t.last_pulse_ms = clock_ms - $urandom_range(0, stall_span);
            t.item_seen = ($urandom_range(3) == 0);
            send_tick(t, 1'b0, '0);
        end
    endtask

    initial
    begin
        cfg_t c;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        now_ms         = '0;
        last_pulse_ms  = '0;
        item_seen      = 1'b0;
        row_typed      = 1'b0;
        row_want       = '0;
        send_idle_pct  = 34;
        recv_idle_pct  = 83;
        hold_requests  = 0;
        quiet_cycles   = 0;
        ticks_in       = 0;
        results_checked = 0;
        settings_loaded = 0;
        backpressure_cycles = 0;
        mismatches     = 0;
        clock_ms       = $urandom();

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);

        // Extremes: fastest possible sequencing, reversal on any stall.
        c = '{8'd0, 8'd255, 8'd180, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
        run_phase(c, 34, 83, 250, 2, 3, 5, 1'b0);

        // Idle angle above the servo range is passed through unchanged.
        c = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'd255, 8'd180,
              32'hFFFF_FFFF, 32'd300, 32'd200, 32'd100};
        run_phase(c, 34, 83, 250, 120, 600, 8, 1'b0);

        // Other extremes: the delay can never end and the roller never reverses.
        c = '{8'd255, 8'd0, 8'd0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'd40};
        run_phase(c, 83, 34, 150, 30, 1000, 10, 1'b0);

        c = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(180)),
              8'($urandom_range(180)), 32'hFFFF_FFFF, 32'($urandom_range(50, 500)),
              32'($urandom_range(20, 400)), 32'($urandom_range(10, 200))};
        run_phase(c, 83, 34, 300, 150, 700, 8, 1'b0);

        // No idling, and one long receiver hold-off so the input backs up.
        c = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(180)),
              8'($urandom_range(180)), 32'hFFFF_FFFF, 32'($urandom_range(50, 500)),
              32'($urandom_range(20, 300)), 32'($urandom_range(10, 150))};
        run_phase(c, 0, 0, 300, 100, 600, 6, 1'b1);

        // Stop threshold below the reverse threshold: a stall past it stops the
        // roller for good, which is why this setting comes last.
        c = '{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(180)),
              8'($urandom_range(180)), 32'd2000, 32'd3000, 32'd100, 32'd50};
        run_phase(c, 0, 0, 150, 60, 1900, 3, 1'b0);

        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Summary: %0d ticks in, %0d results checked over %0d register settings.",
                 ticks_in, results_checked, settings_loaded + 1);
        $display("Summary: %0d stalled input cycles, roller %s at the end, %0d mismatches.",
                 backpressure_cycles,
                 (rl_phase == RL_STOP) ? "stopped for good" : "still running", mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### loader_sequencer_with_roller_stall_guard.f
sv/lsrsg_pkg.sv
sv/lsrsg_step.sv
sv/loader_sequencer_with_roller_stall_guard.sv
bench/loader_sequencer_with_roller_stall_guard_tb.sv
